// ===== rtl/tccc_pkg.sv =====
// shared types and constants for the text console cursor controller
// no dependencies; imported by every module of the block
package tccc_pkg;

  localparam int TAB_SPACES = 4;
  localparam int CNT_W      = $clog2(TAB_SPACES + 1);
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam logic [7:0] COLS_RST = 8'd80;
  localparam logic [7:0] ROWS_RST = 8'd25;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b1;

  typedef enum logic [1:0] {
    OP_PRINT,
    OP_NL,
    OP_CR,
    OP_BS
  } op_kind_t;

  typedef enum logic {
    CMD_DRAW   = 1'b0,
    CMD_SCROLL = 1'b1
  } cmd_t;

  // one classified request as it waits in the queue
  typedef struct packed {
    op_kind_t         kind;
    logic [7:0]       glyph;
    logic [CNT_W-1:0] cells;
  } op_t;

  typedef struct packed {
    logic [7:0] cols;
    logic [7:0] rows;
  } geom_t;

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  glyph_code;
    logic [7:0]  cell_column;
    logic [7:0]  cell_row;
    logic [11:0] pixel_x;
    logic [12:0] pixel_y;
    logic        last_of_run;
  } cmd_word_t;

endpackage

// ===== rtl/tccc_if.sv =====
// channel interfaces: character input and cell command output
// standalone; no package needed
interface tccc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface tccc_out_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  glyph_code;
  logic [7:0]  cell_column;
  logic [7:0]  cell_row;
  logic [11:0] pixel_x;
  logic [12:0] pixel_y;
  logic        last_of_run;

  modport source (output valid, output command, output glyph_code, output cell_column,
                  output cell_row, output pixel_x, output pixel_y, output last_of_run,
                  input ready);
  modport sink (input valid, input command, input glyph_code, input cell_column,
                input cell_row, input pixel_x, input pixel_y, input last_of_run,
                output ready);
endinterface

// ===== rtl/text_console_cursor_controller.sv =====
// accepted characters enter the op queue; the back end registers their commands
// throughput: one command per cycle from the back end while the output can take it;
// one command per one-cell character, TAB_SPACES per tab, one more if a wrap scrolls
// a 4-entry op queue lets input requests keep arriving while a tab run drains
// reset: cursor at column 0 row 0, 80 columns, 25 rows, queue and output empty
module text_console_cursor_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  tccc_in_if.sink                          in_ch,
  tccc_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [tccc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                       cfg_wdata
);
  import tccc_pkg::*;

  geom_t geom_r, geom_nxt;
  logic  push, pop, q_valid, q_full;
  op_t   push_op, head;

  always_comb begin
    geom_nxt = geom_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_COLS: geom_nxt.cols = cfg_wdata;
        REG_ROWS: geom_nxt.rows = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.cols <= COLS_RST;
      geom_r.rows <= ROWS_RST;
    end else begin
      geom_r <= geom_nxt;
    end
  end

  tccc_front u_front (
    .in_ch   (in_ch),
    .q_full  (q_full),
    .push    (push),
    .push_op (push_op)
  );

  tccc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .q_valid (q_valid),
    .q_full  (q_full),
    .head    (head)
  );

  tccc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .geom    (geom_r),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== rtl/tccc_front.sv =====
// front end: accepts character requests and classifies them into queue ops
// depends on tccc_pkg and tccc_in_if
module tccc_front (
  tccc_in_if.sink        in_ch,
  input  logic           q_full,
  output logic           push,
  output tccc_pkg::op_t  push_op
);
  import tccc_pkg::*;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    push_op.kind  = OP_PRINT;
    push_op.glyph = in_ch.char_code;
    push_op.cells = CNT_W'(1);
    case (in_ch.char_code)
      CH_NL: push_op.kind = OP_NL;
      CH_CR: push_op.kind = OP_CR;
      CH_BS: push_op.kind = OP_BS;
      CH_TAB: begin
        // a tab is a run of space cells
        push_op.glyph = CH_SPACE;
        push_op.cells = CNT_W'(TAB_SPACES);
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/tccc_fifo.sv =====
// short op queue between the front end and the back end
// depends on tccc_pkg
module tccc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tccc_pkg::op_t  push_op,
  input  logic           pop,
  output logic           q_valid,
  output logic           q_full,
  output tccc_pkg::op_t  head
);
  import tccc_pkg::*;

  op_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ===== rtl/tccc_back.sv =====
// back end: owns the cursor, expands ops into cell commands, output register
// depends on tccc_pkg and tccc_out_if
module tccc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  tccc_pkg::geom_t geom,
  input  logic            q_valid,
  input  tccc_pkg::op_t   head,
  output logic            pop,
  tccc_out_if.source      out_ch
);
  import tccc_pkg::*;

  logic [7:0]       col_r, col_nxt;
  logic [7:0]       row_r, row_nxt;
  logic             scroll_pend_r, scroll_pend_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [7:0]       glyph_r, glyph_nxt;
  logic             out_valid_r;
  cmd_word_t        out_r, out_nxt;

  logic             can_emit;
  logic [7:0]       cols_eff, rows_eff;
  logic [7:0]       pr_glyph;
  logic [CNT_W-1:0] pr_cells, cells_after;
  logic [8:0]       col_inc, row_inc;
  logic             wrap, nl_scroll;
  logic [7:0]       nl_row;
  logic             emit;
  cmd_t             em_cmd;
  logic [7:0]       em_glyph, em_col, em_row;
  logic             em_last;

  assign can_emit = !out_valid_r || out_ch.ready;
  assign cols_eff = (geom.cols == 8'd0) ? 8'd1 : geom.cols;
  assign rows_eff = (geom.rows == 8'd0) ? 8'd1 : geom.rows;

  // a run in progress takes priority over the queue head
  assign pr_glyph    = (left_r != '0) ? glyph_r : head.glyph;
  assign pr_cells    = (left_r != '0) ? left_r : head.cells;
  assign cells_after = pr_cells - CNT_W'(1);

  assign col_inc   = {1'b0, col_r} + 9'd1;
  assign wrap      = (col_inc >= {1'b0, cols_eff});
  assign row_inc   = {1'b0, row_r} + 9'd1;
  assign nl_scroll = (row_inc >= {1'b0, rows_eff});
  assign nl_row    = nl_scroll ? (rows_eff - 8'd1) : row_inc[7:0];

  always_comb begin
    col_nxt         = col_r;
    row_nxt         = row_r;
    scroll_pend_nxt = scroll_pend_r;
    left_nxt        = left_r;
    glyph_nxt       = glyph_r;
    pop             = 1'b0;
    emit            = 1'b0;
    em_cmd          = CMD_DRAW;
    em_glyph        = 8'd0;
    em_col          = 8'd0;
    em_row          = 8'd0;
    em_last         = 1'b0;
    if (can_emit) begin
      if (scroll_pend_r) begin
        emit            = 1'b1;
        em_cmd          = CMD_SCROLL;
        em_last         = (left_r == '0);
        scroll_pend_nxt = 1'b0;
      end else if (left_r != '0 || (q_valid && head.kind == OP_PRINT)) begin
        pop       = (left_r == '0);
        emit      = 1'b1;
        em_glyph  = pr_glyph;
        em_col    = col_r;
        em_row    = row_r;
        left_nxt  = cells_after;
        glyph_nxt = pr_glyph;
        if (wrap) begin
          col_nxt         = 8'd0;
          row_nxt         = nl_row;
          scroll_pend_nxt = nl_scroll;
        end else begin
          col_nxt = col_inc[7:0];
        end
        em_last = (cells_after == '0) && !(wrap && nl_scroll);
      end else if (q_valid) begin
        pop = 1'b1;
        case (head.kind)
          OP_NL: begin
            col_nxt = 8'd0;
            row_nxt = nl_row;
            if (nl_scroll) begin
              emit    = 1'b1;
              em_cmd  = CMD_SCROLL;
              em_last = 1'b1;
            end
          end
          OP_CR: col_nxt = 8'd0;
          OP_BS: begin
            if (col_r != 8'd0) begin
              col_nxt  = col_r - 8'd1;
              emit     = 1'b1;
              em_glyph = CH_SPACE;
              em_col   = col_r - 8'd1;
              em_row   = row_r;
              em_last  = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // pixel origin: col*12+1 and row*18+2, zero on scroll
  always_comb begin
    out_nxt.command     = em_cmd;
    out_nxt.glyph_code  = em_glyph;
    out_nxt.cell_column = em_col;
    out_nxt.cell_row    = em_row;
    out_nxt.last_of_run = em_last;
    if (em_cmd == CMD_SCROLL) begin
      out_nxt.pixel_x = 12'd0;
      out_nxt.pixel_y = 13'd0;
    end else begin
      out_nxt.pixel_x = ({4'd0, em_col} << 3) + ({4'd0, em_col} << 2) + 12'd1;
      out_nxt.pixel_y = ({5'd0, em_row} << 4) + ({5'd0, em_row} << 1) + 13'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r         <= 8'd0;
      row_r         <= 8'd0;
      scroll_pend_r <= 1'b0;
      left_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      scroll_pend_r <= scroll_pend_nxt;
      left_r        <= left_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    glyph_r <= glyph_nxt;
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.command     = out_r.command;
  assign out_ch.glyph_code  = out_r.glyph_code;
  assign out_ch.cell_column = out_r.cell_column;
  assign out_ch.cell_row    = out_r.cell_row;
  assign out_ch.pixel_x     = out_r.pixel_x;
  assign out_ch.pixel_y     = out_r.pixel_y;
  assign out_ch.last_of_run = out_r.last_of_run;

endmodule
